FILE: src/at_frc_pkg.sv
package at_frc_pkg;

	localparam int LINE_MAX_DEF = 96;

	localparam int KIND_W    = 2;
	localparam int BYTE_W    = 8;
	localparam int TMO_W     = 16;
	localparam int OUTCOME_W = 3;
	localparam int LEN_W     = 8;
	localparam int CMP_W     = 4;

	localparam int OK_LEN    = 2;
	localparam int ERROR_LEN = 5;
	localparam int CME_LEN   = 10;

	localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_INFO    = 3'd0,
		OUT_OK      = 3'd1,
		OUT_ERROR   = 3'd2,
		OUT_CME     = 3'd3,
		OUT_TIMEOUT = 3'd4
	} outcome_t;

	typedef struct packed {
		logic             valid;
		outcome_t         outcome;
		logic [LEN_W-1:0] length;
		logic             finished;
	} result_t;

	function automatic logic [BYTE_W-1:0] ok_char(logic [CMP_W-1:0] p);
		logic [BYTE_W-1:0] c;
		case (p)
			4'd0:    c = "O";
			4'd1:    c = "K";
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] error_char(logic [CMP_W-1:0] p);
		logic [BYTE_W-1:0] c;
		case (p)
			4'd0:    c = "E";
			4'd1:    c = "R";
			4'd2:    c = "R";
			4'd3:    c = "O";
			4'd4:    c = "R";
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] cme_char(logic [CMP_W-1:0] p);
		logic [BYTE_W-1:0] c;
		case (p)
			4'd0:    c = "+";
			4'd1:    c = "C";
			4'd2:    c = "M";
			4'd3:    c = "E";
			4'd4:    c = " ";
			4'd5:    c = "E";
			4'd6:    c = "R";
			4'd7:    c = "R";
			4'd8:    c = "O";
			4'd9:    c = "R";
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

endpackage

FILE: src/at_frc_classify.sv
module at_frc_classify #(
	parameter int LINE_MAX = at_frc_pkg::LINE_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [at_frc_pkg::KIND_W-1:0]     kind,
	input  logic [at_frc_pkg::BYTE_W-1:0]     rx_byte,
	input  logic [at_frc_pkg::TMO_W-1:0]      wait_limit,
	output at_frc_pkg::result_t               res
);

	localparam int SLEN_W = $clog2(LINE_MAX);
	localparam logic [SLEN_W-1:0] STORE_MAX = SLEN_W'(LINE_MAX - 1);
	localparam int CW = at_frc_pkg::CMP_W;

	logic                             waiting_q, waiting_n;
	logic [at_frc_pkg::TMO_W-1:0]     elapsed_q, elapsed_n, elapsed_inc;
	logic [at_frc_pkg::TMO_W-1:0]     limit_q, limit_n;
	logic [SLEN_W-1:0]                stored_q, stored_n;
	logic [CW-1:0]                    cmp_q, cmp_n;
	logic                             zero_q, zero_n;
	logic                             ok_q, ok_n;
	logic                             err_q, err_n;
	logic                             cme_q, cme_n;
	at_frc_pkg::outcome_t             line_outcome;

	always_comb begin
		if (ok_q && cmp_q == CW'(at_frc_pkg::OK_LEN)) begin
			line_outcome = at_frc_pkg::OUT_OK;
		end else if (err_q && cmp_q == CW'(at_frc_pkg::ERROR_LEN)) begin
			line_outcome = at_frc_pkg::OUT_ERROR;
		end else if (cme_q && cmp_q >= CW'(at_frc_pkg::CME_LEN)) begin
			line_outcome = at_frc_pkg::OUT_CME;
		end else begin
			line_outcome = at_frc_pkg::OUT_INFO;
		end
	end

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		waiting_n = waiting_q;
		elapsed_n = elapsed_q;
		limit_n   = limit_q;
		stored_n  = stored_q;
		cmp_n     = cmp_q;
		zero_n    = zero_q;
		ok_n      = ok_q;
		err_n     = err_q;
		cme_n     = cme_q;
		res       = '{valid: 1'b0, outcome: at_frc_pkg::OUT_INFO, length: '0, finished: 1'b0};
		unique case (at_frc_pkg::kind_t'(kind))
			at_frc_pkg::KIND_START: begin
				waiting_n = (wait_limit != '0);
				elapsed_n = '0;
				limit_n   = wait_limit;
				stored_n  = '0;
				cmp_n     = '0;
				zero_n    = 1'b0;
				ok_n      = 1'b1;
				err_n     = 1'b1;
				cme_n     = 1'b1;
				if (wait_limit == '0) begin
					res = '{valid: 1'b1, outcome: at_frc_pkg::OUT_TIMEOUT, length: '0,
						finished: 1'b1};
				end
			end
			at_frc_pkg::KIND_TICK: begin
				if (waiting_q) begin
					elapsed_n = elapsed_inc;
					if (elapsed_inc >= limit_q) begin
						waiting_n = 1'b0;
						stored_n  = '0;
						cmp_n     = '0;
						zero_n    = 1'b0;
						ok_n      = 1'b1;
						err_n     = 1'b1;
						cme_n     = 1'b1;
						res = '{valid: 1'b1, outcome: at_frc_pkg::OUT_TIMEOUT, length: '0,
							finished: 1'b1};
					end
				end
			end
			at_frc_pkg::KIND_BYTE: begin
				if (waiting_q) begin
					if (rx_byte == at_frc_pkg::CHAR_CR) begin
						if (stored_q != '0) begin
							stored_n = '0;
							cmp_n    = '0;
							zero_n   = 1'b0;
							ok_n     = 1'b1;
							err_n    = 1'b1;
							cme_n    = 1'b1;
							if (line_outcome != at_frc_pkg::OUT_INFO) begin
								waiting_n = 1'b0;
							end
							res = '{valid: 1'b1, outcome: line_outcome,
								length: at_frc_pkg::LEN_W'(stored_q),
								finished: (line_outcome != at_frc_pkg::OUT_INFO)};
						end
					end else if (rx_byte != at_frc_pkg::CHAR_LF && stored_q < STORE_MAX) begin
						stored_n = stored_q + 1'b1;
						if (!zero_q) begin
							if (rx_byte == at_frc_pkg::CHAR_NUL) begin
								zero_n = 1'b1;
							end else begin
								ok_n  = ok_q && cmp_q < CW'(at_frc_pkg::OK_LEN)
									&& rx_byte == at_frc_pkg::ok_char(cmp_q);
								err_n = err_q && cmp_q < CW'(at_frc_pkg::ERROR_LEN)
									&& rx_byte == at_frc_pkg::error_char(cmp_q);
								if (cmp_q < CW'(at_frc_pkg::CME_LEN)) begin
									cme_n = cme_q && rx_byte == at_frc_pkg::cme_char(cmp_q);
								end
								cmp_n = (cmp_q == '1) ? cmp_q : cmp_q + 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			elapsed_q <= '0;
			limit_q   <= '0;
			stored_q  <= '0;
			cmp_q     <= '0;
			zero_q    <= 1'b0;
			ok_q      <= 1'b1;
			err_q     <= 1'b1;
			cme_q     <= 1'b1;
		end else if (step) begin
			waiting_q <= waiting_n;
			elapsed_q <= elapsed_n;
			limit_q   <= limit_n;
			stored_q  <= stored_n;
			cmp_q     <= cmp_n;
			zero_q    <= zero_n;
			ok_q      <= ok_n;
			err_q     <= err_n;
			cme_q     <= cme_n;
		end
	end

endmodule

FILE: src/at_frc_out_reg.sv
module at_frc_out_reg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  at_frc_pkg::result_t                 res_in,
	output logic                                space,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [at_frc_pkg::LEN_W-1:0]        m_tdata,  // [7:0] line_length
	output logic [at_frc_pkg::OUTCOME_W-1:0]    m_tuser,  // [2:0] outcome
	output logic                                m_tlast   // finished
);

	logic                              valid_q;
	at_frc_pkg::outcome_t              outcome_q;
	logic [at_frc_pkg::LEN_W-1:0]      length_q;
	logic                              finished_q;

	assign space = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			outcome_q  <= res_in.outcome;
			length_q   <= res_in.length;
			finished_q <= res_in.finished;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = length_q;
	assign m_tuser  = outcome_q;
	assign m_tlast  = finished_q;

endmodule

FILE: src/at_final_response_classifier_core.sv
// AT final-response classifier.
// Slave channel: one transfer per event. s_tuser = kind (start, rx byte,
// 1 ms tick); s_tdata = rx_byte in [7:0], wait limit in ticks in [23:8].
// Master channel: at most one transfer per event. m_tuser = outcome
// (info, OK, ERROR, CME error, timeout); m_tdata = line length;
// m_tlast = the wait is over.
// A start arms the wait (a zero limit times out at once) and drops any
// partial line; bytes form lines that end on CR, LF is ignored; events
// arriving while not armed are dropped. A result passes through the input
// register, then the result register, before it is presented.
// Throughput: one transfer per cycle unless a result has to wait; matching
// is incremental per byte, so the per-item path is one compare and a small
// counter update. Reset clears the wait, the line state and both valid flags.
// A stalled master side holds its result; the input register still takes
// events that give no result, and stops only when a result has to wait.
module at_final_response_classifier_core #(
	parameter int LINE_MAX = at_frc_pkg::LINE_MAX_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	input  logic [at_frc_pkg::BYTE_W+at_frc_pkg::TMO_W-1:0] s_tdata, // [7:0] rx_byte, [23:8] wait_limit
	input  logic [at_frc_pkg::KIND_W-1:0]                   s_tuser, // [1:0] kind
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	output logic [at_frc_pkg::LEN_W-1:0]                    m_tdata, // [7:0] line_length
	output logic [at_frc_pkg::OUTCOME_W-1:0]                m_tuser, // [2:0] outcome
	output logic                                            m_tlast  // finished
);

	logic                                 valid_s1;
	logic [at_frc_pkg::KIND_W-1:0]        kind_s1;
	logic [at_frc_pkg::BYTE_W-1:0]        byte_s1;
	logic [at_frc_pkg::TMO_W-1:0]         tmo_s1;
	at_frc_pkg::result_t                  res;
	logic                                 space;
	logic                                 go;

	assign go       = valid_s1 && (!res.valid || space);
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata[at_frc_pkg::BYTE_W-1:0];
			tmo_s1  <= s_tdata[at_frc_pkg::BYTE_W +: at_frc_pkg::TMO_W];
		end
	end

	at_frc_classify #(
		.LINE_MAX(LINE_MAX)
	) u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (go),
		.kind      (kind_s1),
		.rx_byte   (byte_s1),
		.wait_limit(tmo_s1),
		.res       (res)
	);

	at_frc_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (go && res.valid),
		.res_in  (res),
		.space   (space),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

FILE: src/at_frc_checker.sv
module at_frc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [at_frc_pkg::LEN_W-1:0]        m_tdata,
	input logic [at_frc_pkg::OUTCOME_W-1:0]    m_tuser,
	input logic                                m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == at_frc_pkg::OUT_TIMEOUT |-> m_tlast && m_tdata == '0)
		else $error("timeout must be final with zero length");

	a_info: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == at_frc_pkg::OUT_INFO |-> !m_tlast && m_tdata != '0)
		else $error("info line must be non-final and non-empty");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == at_frc_pkg::OUT_OK || m_tuser == at_frc_pkg::OUT_ERROR
			|| m_tuser == at_frc_pkg::OUT_CME) |-> m_tlast && m_tdata != '0)
		else $error("final code must end the wait with a stored line");

endmodule

bind at_final_response_classifier_core at_frc_checker u_frc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

FILE: tb/sv/at_frc_response_checker.sv
module at_frc_response_checker #(
	parameter int LINE_MAX = at_frc_pkg::LINE_MAX_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            s_tvalid,
	input  logic                                            s_tready,
	input  logic [at_frc_pkg::BYTE_W+at_frc_pkg::TMO_W-1:0] s_tdata,
	input  logic [at_frc_pkg::KIND_W-1:0]                   s_tuser,
	input  logic                                            m_tvalid,
	input  logic                                            m_tready,
	input  logic [at_frc_pkg::LEN_W-1:0]                    m_tdata,
	input  logic [at_frc_pkg::OUTCOME_W-1:0]                m_tuser,
	input  logic                                            m_tlast,
	output int                                              fail_cnt,
	output int                                              pend_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [8*at_frc_pkg::OK_LEN-1:0]    TXT_OK    = "OK";
	localparam logic [8*at_frc_pkg::ERROR_LEN-1:0] TXT_ERROR = "ERROR";
	localparam logic [8*at_frc_pkg::CME_LEN-1:0]   TXT_CME   = "+CME ERROR";

	typedef struct {
		at_frc_pkg::outcome_t         outcome;
		logic [at_frc_pkg::LEN_W-1:0] len;
		logic                         fin;
	} line_result_t;

	line_result_t    expected_q[$];
	int              fails;

	logic                         armed;
	logic [at_frc_pkg::TMO_W-1:0] ticks_seen;
	logic [at_frc_pkg::TMO_W-1:0] tick_limit;
	logic [at_frc_pkg::LEN_W-1:0] held_len;
	logic [at_frc_pkg::LEN_W-1:0] cmp_len;
	logic                         nul_seen;
	logic                         ok_hit;
	logic                         err_hit;
	logic                         cme_hit;

	function automatic void restart_line();
		held_len = '0;
		cmp_len  = '0;
		nul_seen = 1'b0;
		ok_hit   = 1'b1;
		err_hit  = 1'b1;
		cme_hit  = 1'b1;
	endfunction

	// prefix flags advance one character at a time; text after a NUL is not compared
	function automatic void absorb_char(input logic [at_frc_pkg::BYTE_W-1:0] b);
		int p;
		p = int'(cmp_len);
		if (nul_seen)
			return;
		if (b == at_frc_pkg::CHAR_NUL) begin
			nul_seen = 1'b1;
			return;
		end
		if (p < at_frc_pkg::OK_LEN)
			ok_hit = ok_hit && (b == TXT_OK[8*(at_frc_pkg::OK_LEN-1-p) +: 8]);
		else
			ok_hit = 1'b0;
		if (p < at_frc_pkg::ERROR_LEN)
			err_hit = err_hit && (b == TXT_ERROR[8*(at_frc_pkg::ERROR_LEN-1-p) +: 8]);
		else
			err_hit = 1'b0;
		if (p < at_frc_pkg::CME_LEN)
			cme_hit = cme_hit && (b == TXT_CME[8*(at_frc_pkg::CME_LEN-1-p) +: 8]);
		cmp_len = cmp_len + 1'b1;
	endfunction

	function automatic bit classify_event(input logic [at_frc_pkg::KIND_W-1:0] kind,
			input logic [at_frc_pkg::BYTE_W-1:0] b, input logic [at_frc_pkg::TMO_W-1:0] tmo,
			output line_result_t r);
		r = '{at_frc_pkg::OUT_TIMEOUT, '0, 1'b1};
		if (kind == at_frc_pkg::KIND_START) begin
			armed      = 1'b1;
			ticks_seen = '0;
			tick_limit = tmo;
			restart_line();
			if (tmo == '0) begin
				armed = 1'b0;
				return 1'b1;
			end
			return 1'b0;
		end
		if (!armed)
			return 1'b0;
		if (kind == at_frc_pkg::KIND_TICK) begin
			if (ticks_seen != '1)
				ticks_seen = ticks_seen + 1'b1;
			if (ticks_seen >= tick_limit) begin
				armed = 1'b0;
				restart_line();
				return 1'b1;
			end
			return 1'b0;
		end
		if (kind != at_frc_pkg::KIND_BYTE || b == at_frc_pkg::CHAR_LF)
			return 1'b0;
		if (b == at_frc_pkg::CHAR_CR) begin
			if (held_len == '0)
				return 1'b0;
			r.len = held_len;
			if (ok_hit && cmp_len == at_frc_pkg::OK_LEN)
				r.outcome = at_frc_pkg::OUT_OK;
			else if (err_hit && cmp_len == at_frc_pkg::ERROR_LEN)
				r.outcome = at_frc_pkg::OUT_ERROR;
			else if (cme_hit && cmp_len >= at_frc_pkg::CME_LEN)
				r.outcome = at_frc_pkg::OUT_CME;
			else
				r.outcome = at_frc_pkg::OUT_INFO;
			r.fin = (r.outcome != at_frc_pkg::OUT_INFO);
			if (r.fin)
				armed = 1'b0;
			restart_line();
			return 1'b1;
		end
		if (held_len < LINE_MAX - 1) begin
			absorb_char(b);
			held_len = held_len + 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_result_t r;
		if (!arst_n) begin
			armed      = 1'b0;
			ticks_seen = '0;
			tick_limit = '0;
			restart_line();
			expected_q.delete();
			fails = 0;
			fail_cnt <= 0;
			pend_cnt <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (classify_event(s_tuser, s_tdata[at_frc_pkg::BYTE_W-1:0],
						s_tdata[at_frc_pkg::BYTE_W +: at_frc_pkg::TMO_W], r))
					expected_q.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer: outcome %0d length %0d finished %0b",
						m_tuser, m_tdata, m_tlast);
					fails++;
				end else begin
					r = expected_q.pop_front();
					if (m_tuser !== r.outcome) begin
						$error("outcome: expected %0d, actual %0d", r.outcome, m_tuser);
						fails++;
					end
					if (m_tdata !== r.len) begin
						$error("line_length: expected %0d, actual %0d", r.len, m_tdata);
						fails++;
					end
					if (m_tlast !== r.fin) begin
						$error("finished: expected %0b, actual %0b", r.fin, m_tlast);
						fails++;
					end
				end
			end
			fail_cnt <= fails;
			pend_cnt <= expected_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_at_final_response_classifier_core.sv
module tb_at_final_response_classifier_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [at_frc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 450;

	logic                                            clk;
	logic                                            arst_n;
	logic                                            s_tvalid;
	logic                                            s_tready;
	logic [at_frc_pkg::BYTE_W+at_frc_pkg::TMO_W-1:0] s_tdata;
	logic [at_frc_pkg::KIND_W-1:0]                   s_tuser;
	logic                                            m_tvalid;
	logic                                            m_tready;
	logic [at_frc_pkg::LEN_W-1:0]                    m_tdata;
	logic [at_frc_pkg::OUTCOME_W-1:0]                m_tuser;
	logic                                            m_tlast;

	int fail_cnt;
	int pend_cnt;
	int hold_req;
	int sent_items;
	bit idle_on;

	string near_miss[$] = '{"O", "OKK", "OK ", "ERRO", "ERRORS", "+CME ERRO", "+CME",
		"ok", "+CMS ERROR", "ERROR OK", " OK", "+CME  ERROR"};
	string finals[$] = '{"OK", "ERROR", "+CME ERROR"};

	at_final_response_classifier_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	at_frc_response_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.fail_cnt (fail_cnt),
		.pend_cnt (pend_cnt)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("at_final_response_classifier_core: mismatch");
		$finish;
	end

	// result side: random stall per transfer while idle gaps are on, long hold on request
	initial begin
		int stall;
		int hold;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				hold     = hold_req;
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && hold_req == 0);
		end
	end

	task automatic push_event(input logic [at_frc_pkg::KIND_W-1:0] kind,
			input logic [at_frc_pkg::BYTE_W-1:0] b, input logic [at_frc_pkg::TMO_W-1:0] tmo);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {tmo, b};
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	task automatic send_byte(input logic [at_frc_pkg::BYTE_W-1:0] b);
		push_event(at_frc_pkg::KIND_BYTE, b, at_frc_pkg::TMO_W'($urandom_range(0, 65535)));
	endtask

	task automatic send_tick();
		push_event(at_frc_pkg::KIND_TICK, at_frc_pkg::BYTE_W'($urandom_range(0, 255)),
			at_frc_pkg::TMO_W'($urandom_range(0, 65535)));
	endtask

	task automatic send_start(input logic [at_frc_pkg::TMO_W-1:0] tmo);
		push_event(at_frc_pkg::KIND_START, at_frc_pkg::BYTE_W'($urandom_range(0, 255)), tmo);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pend_cnt != 0)
			@(posedge clk);
	endtask

	// line categories: 0..3 end the wait, 4..6 and 8 do not, 7 does when it opens with +CME ERROR
	task automatic send_line(input int cat);
		int n;
		int sel;
		case (cat)
			0, 1: begin
				send_str(finals[cat]);
			end
			2: begin
				send_str(finals[2]);
				if ($urandom_range(0, 1))
					send_str($sformatf(": %0d", $urandom_range(0, 999)));
			end
			3: begin
				send_str(finals[$urandom_range(0, 2)]);
				send_byte(at_frc_pkg::CHAR_NUL);
				repeat ($urandom_range(0, 4))
					send_byte(at_frc_pkg::BYTE_W'($urandom_range(0, 255)));
			end
			4: begin
				send_str(near_miss[$urandom_range(0, near_miss.size() - 1)]);
			end
			5: begin
				send_byte(at_frc_pkg::CHAR_NUL);
				send_str(finals[$urandom_range(0, 2)]);
			end
			6: begin
				repeat ($urandom_range(1, 12))
					send_byte(at_frc_pkg::BYTE_W'($urandom_range(0, 255)));
			end
			7: begin
				n = $urandom_range(90, 110);
				if ($urandom_range(0, 1)) begin
					send_str(finals[2]);
					n -= at_frc_pkg::CME_LEN;
				end
				repeat (n) send_byte(at_frc_pkg::BYTE_W'($urandom_range(32, 126)));
			end
			default: begin
			end
		endcase
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			send_byte(at_frc_pkg::CHAR_CR);
		end else if (sel < 85) begin
			send_byte(at_frc_pkg::CHAR_CR);
			send_byte(at_frc_pkg::CHAR_LF);
		end else begin
			send_byte(at_frc_pkg::CHAR_LF);
			send_byte(at_frc_pkg::CHAR_CR);
		end
	endtask

	function automatic int pick_info_cat();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 30)
			return 4;
		if (sel < 40)
			return 5;
		if (sel < 85)
			return 6;
		if (sel < 90)
			return 7;
		return 8;
	endfunction

	task automatic run_session();
		int sel;
		int tmo;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			tmo = 0;
		else if (sel < 50)
			tmo = $urandom_range(1, 30);
		else if (sel < 80)
			tmo = $urandom_range(31, 300);
		else
			tmo = $urandom_range(0, 65535);
		send_start(at_frc_pkg::TMO_W'(tmo));
		repeat ($urandom_range(0, 3)) begin
			repeat ($urandom_range(0, 2)) send_tick();
			send_line(pick_info_cat());
		end
		sel = $urandom_range(0, 99);
		if (sel < 75) begin
			send_line($urandom_range(0, 3));
		end else if (sel < 90) begin
			repeat (tmo > 60 ? 5 : tmo) send_tick();
		end else begin
			// partial line, dropped by the next start
			send_str(finals[$urandom_range(0, 2)]);
		end
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3))
				push_event(at_frc_pkg::KIND_W'($urandom_range(1, 3)),
					at_frc_pkg::BYTE_W'($urandom_range(0, 255)),
					at_frc_pkg::TMO_W'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		int session;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= at_frc_pkg::KIND_START;
		s_tdata  <= '0;
		hold_req = 0;
		idle_on  = 1'b1;
		sent_items = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle drops, zero limit, tick timeout, unused kind, exact codes,
		// empty line, leading NUL, restart while waiting
		send_tick();
		send_byte(8'hFF);
		push_event(KIND_UNUSED, 8'hA5, 16'hFFFF);
		send_start(16'd0);
		send_start(16'd2);
		send_tick();
		push_event(KIND_UNUSED, 8'h5A, 16'h0000);
		send_tick();
		send_start(16'hFFFF);
		send_str("OK");
		send_byte(at_frc_pkg::CHAR_LF);
		send_byte(at_frc_pkg::CHAR_CR);
		send_start(16'd40);
		send_byte(at_frc_pkg::CHAR_CR);
		send_byte(at_frc_pkg::CHAR_NUL);
		send_str("OK");
		send_byte(at_frc_pkg::CHAR_CR);
		send_start(16'd40);
		send_str("ERROR");
		send_byte(at_frc_pkg::CHAR_CR);

		session = 0;
		while (sent_items < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (session == 5) begin
				idle_on  = 1'b0;
				hold_req = 60;
				send_start(16'hFFFF);
				repeat (12) send_line(6);
			end else if (session % 15 == 10) begin
				drain();
				run_session();
			end else begin
				run_session();
			end
			session++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && pend_cnt == 0)
			$display("at_final_response_classifier_core: match");
		else
			$display("at_final_response_classifier_core: mismatch");
		$finish;
	end

endmodule
